@@ rtl/kdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_pkg
// Shared constants, Taylor divide tables and payload types for the
// keypoint row decoder.
// ----------------------------------------------------------------------------
package kdr_pkg;

  localparam int unsigned EXP_LAT    = 17;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned SQRT_STEPS = 14;

  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [13:0] COORD_MAX  = 14'd10240;
  localparam logic [15:0] CONF_RESET = 16'd32768;
  localparam logic [15:0] Q16_MAX    = 16'hFFFF;
  localparam logic [10:0] BOX_MAX    = 11'd640;

  // floor(p / n) = (p * recip(n)) >> shift(n), exact for p < 2^30
  function automatic logic [30:0] taylor_recip(input int n);
    logic [30:0] r;
    case (n)
      3:       r = 31'd1431655766;
      5:       r = 31'd1717986919;
      6:       r = 31'd1431655766;
      7:       r = 31'd1227133514;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

  function automatic int taylor_shift(input int n);
    int s;
    case (n)
      2:       s = 31;
      3:       s = 32;
      4:       s = 32;
      default: s = 33;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic             neg;
    logic [1:0]       cbest;
    logic [3:0]       dbest;
    logic [3:0][31:0] corners;
    logic [39:0]      box;
  } meta_t;

  typedef struct packed {
    logic [13:0] len;
    logic [13:0] wid;
    logic [1:0]  rmode;
  } geo_t;

  typedef struct packed {
    logic [15:0] confidence;
    logic [1:0]  color_class;
    logic [3:0]  digit_class;
    logic [31:0] corner_a_out;
    logic [31:0] corner_b_out;
    logic [31:0] corner_c_out;
    logic [31:0] corner_d_out;
    logic [39:0] box_packed;
    logic [13:0] edge_length;
    logic [13:0] edge_width;
    logic [15:0] aspect_ratio;
  } res_t;

endpackage

@@ rtl/kdr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_if
// Row, result and threshold channels (valid/ready).
// ----------------------------------------------------------------------------
interface kdr_row_if;
  logic               valid;
  logic               ready;
  logic [31:0]        corner_a_xy;
  logic [31:0]        corner_b_xy;
  logic [31:0]        corner_c_xy;
  logic [31:0]        corner_d_xy;
  logic signed [15:0] objectness_logit;
  logic [63:0]        color_logits;
  logic [63:0]        digit_logits_low;
  logic [63:0]        digit_logits_high;
  logic signed [15:0] digit_logit_last;

  modport source (output valid, corner_a_xy, corner_b_xy, corner_c_xy, corner_d_xy,
                  objectness_logit, color_logits, digit_logits_low, digit_logits_high,
                  digit_logit_last, input ready);
  modport sink (input valid, corner_a_xy, corner_b_xy, corner_c_xy, corner_d_xy,
                objectness_logit, color_logits, digit_logits_low, digit_logits_high,
                digit_logit_last, output ready);
endinterface

interface kdr_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] confidence;
  logic [1:0]  color_class;
  logic [3:0]  digit_class;
  logic [31:0] corner_a_out;
  logic [31:0] corner_b_out;
  logic [31:0] corner_c_out;
  logic [31:0] corner_d_out;
  logic [39:0] box_packed;
  logic [13:0] edge_length;
  logic [13:0] edge_width;
  logic [15:0] aspect_ratio;

  modport source (output valid, confidence, color_class, digit_class, corner_a_out,
                  corner_b_out, corner_c_out, corner_d_out, box_packed, edge_length,
                  edge_width, aspect_ratio, input ready);
  modport sink (input valid, confidence, color_class, digit_class, corner_a_out,
                corner_b_out, corner_c_out, corner_d_out, box_packed, edge_length,
                edge_width, aspect_ratio, output ready);
endinterface

interface kdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] conf_threshold;

  modport source (output valid, conf_threshold, input ready);
  modport sink (input valid, conf_threshold, output ready);
endinterface

@@ rtl/keypoint_detection_row_decode_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_detection_row_decode_core
// Decodes one detector row per word: objectness sigmoid, class argmax,
// softmax confidence, clamped corners, box, edge lengths and their ratio.
// ----------------------------------------------------------------------------
// Pipeline: row accept to result valid passes 39 pipeline stages
//   plus the output register. Rows that fail a threshold produce no word.
// Throughput: one row per cycle with the skid empty; the 17-step divider lanes
//   and 17-stage exp units are fully pipelined; nothing is shared between rows.
// Stall: a two-entry output buffer (register plus skid) decouples the sides;
//   the pipeline freezes only when both entries are full.
// Reset: pipeline and output empty, conf_threshold = 0.5 (32768).
// ----------------------------------------------------------------------------
module keypoint_detection_row_decode_core (
  input  logic clk_i,
  input  logic rst_ni,
  kdr_cfg_if.sink   cfg_i,
  kdr_row_if.sink   row_i,
  kdr_res_if.source res_o
);

  // ratio selection codes
  localparam logic [1:0] RM_DIV  = 2'd0;
  localparam logic [1:0] RM_SAT  = 2'd1;
  localparam logic [1:0] RM_ZERO = 2'd2;

  // stage numbers
  localparam int unsigned ST_GEO = 20;
  localparam int unsigned ST_DIV = 21;
  localparam int unsigned ST_END = ST_DIV + kdr_pkg::DIV_STEPS + 1;  // 39

  // ---------------------------------------------------------------------------
  // Global flow control
  // ---------------------------------------------------------------------------
  logic              adv;
  logic [ST_END:1]   vld_q;
  logic [15:0]       thr_q;
  logic              out_vld_q;
  logic              skid_vld_q;
  kdr_pkg::res_t     out_q;
  kdr_pkg::res_t     skid_q;

  assign adv         = !skid_vld_q;
  assign row_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= kdr_pkg::CONF_RESET;
    end else begin
      if (adv) vld_q <= {vld_q[ST_END-1:1], row_i.valid};
      if (cfg_i.valid) thr_q <= cfg_i.conf_threshold;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [3:0][31:0]  cor1_q;
  logic [15:0]       obj1_q;
  logic [3:0][15:0]  col1_q;
  logic [8:0][15:0]  dig1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor1_q <= {row_i.corner_d_xy, row_i.corner_c_xy, row_i.corner_b_xy, row_i.corner_a_xy};
      obj1_q <= row_i.objectness_logit;
      col1_q <= row_i.color_logits;
      dig1_q <= {row_i.digit_logit_last, row_i.digit_logits_high, row_i.digit_logits_low};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: argmax (first index wins ties), |logit|, corner clamp
  // ---------------------------------------------------------------------------
  function automatic logic [13:0] clamp_coord(input logic [15:0] c);
    logic [13:0] r;
    if (c[15]) r = 14'd0;
    else if (c[14:0] > {1'b0, kdr_pkg::COORD_MAX}) r = kdr_pkg::COORD_MAX;
    else r = c[13:0];
    return r;
  endfunction

  logic signed [15:0] dmax;
  logic [3:0]         dbest;
  logic signed [15:0] cmax;
  logic [1:0]         cbest;

  always_comb begin
    dmax  = $signed(dig1_q[0]);
    dbest = 4'd0;
    for (int i = 1; i < 9; i++) begin
      if ($signed(dig1_q[i]) > dmax) begin
        dmax  = $signed(dig1_q[i]);
        dbest = 4'(i);
      end
    end
    cmax  = $signed(col1_q[0]);
    cbest = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if ($signed(col1_q[i]) > cmax) begin
        cmax  = $signed(col1_q[i]);
        cbest = 2'(i);
      end
    end
  end

  logic [15:0]           dmax2_q;
  logic [8:0][15:0]      dig2_q;
  logic [3:0]            dbest2_q;
  logic [1:0]            cbest2_q;
  logic                  neg2_q;
  logic [15:0]           mag2_q;
  logic [3:0][1:0][13:0] cl2_q;   // [corner][0 = x, 1 = y]

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmax2_q  <= dmax;
      dig2_q   <= dig1_q;
      dbest2_q <= dbest;
      cbest2_q <= cbest;
      neg2_q   <= obj1_q[15];
      mag2_q   <= obj1_q[15] ? 16'(-obj1_q) : obj1_q;
      for (int i = 0; i < 4; i++) begin
        cl2_q[i][0] <= clamp_coord(cor1_q[i][15:0]);
        cl2_q[i][1] <= clamp_coord(cor1_q[i][31:16]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3..19: ten exp units, nine digit gaps plus |objectness|
  // ---------------------------------------------------------------------------
  logic [9:0][15:0] exp_u;
  logic [16:0]      exp_e [10];
  logic [16:0]      dgap [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dgap[i]  = {dmax2_q[15], dmax2_q} - {dig2_q[i][15], dig2_q[i]};
      exp_u[i] = dgap[i][15:0];
    end
    exp_u[9] = mag2_q;
  end

  for (genvar g = 0; g < 10; g++) begin : g_exp
    kdr_exp u_exp (
      .clk_i (clk_i),
      .en_i  (adv),
      .u_i   (exp_u[g]),
      .e_o   (exp_e[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 3: box, squared deltas; side data travels in meta_q
  // ---------------------------------------------------------------------------
  kdr_pkg::meta_t meta3;
  kdr_pkg::meta_t meta_q [3:ST_END-1];
  logic [13:0]    minx, maxx, miny, maxy;
  logic [13:0]    spanx, spany;
  logic signed [14:0] dl [4];
  logic signed [29:0] sqr [4];
  logic [26:0]    sq3_q [4];   // len x, len y, wid x, wid y

  always_comb begin
    minx = cl2_q[0][0];
    maxx = cl2_q[0][0];
    miny = cl2_q[0][1];
    maxy = cl2_q[0][1];
    for (int i = 1; i < 4; i++) begin
      if (cl2_q[i][0] < minx) minx = cl2_q[i][0];
      if (cl2_q[i][0] > maxx) maxx = cl2_q[i][0];
      if (cl2_q[i][1] < miny) miny = cl2_q[i][1];
      if (cl2_q[i][1] > maxy) maxy = cl2_q[i][1];
    end
    spanx = maxx - minx;
    spany = maxy - miny;
    meta3.neg   = neg2_q;
    meta3.cbest = cbest2_q;
    meta3.dbest = dbest2_q;
    for (int i = 0; i < 4; i++) begin
      meta3.corners[i] = {2'b0, cl2_q[i][1], 2'b0, cl2_q[i][0]};
    end
    meta3.box = {spany[13:4], spanx[13:4], miny[13:4], minx[13:4]};

    dl[0] = $signed({1'b0, cl2_q[0][0]}) - $signed({1'b0, cl2_q[3][0]});
    dl[1] = $signed({1'b0, cl2_q[0][1]}) - $signed({1'b0, cl2_q[3][1]});
    dl[2] = $signed({1'b0, cl2_q[0][0]}) - $signed({1'b0, cl2_q[1][0]});
    dl[3] = $signed({1'b0, cl2_q[0][1]}) - $signed({1'b0, cl2_q[1][1]});
    for (int i = 0; i < 4; i++) sqr[i] = dl[i] * dl[i];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[3] <= meta3;
      for (int s = 4; s < ST_END; s++) meta_q[s] <= meta_q[s-1];
      for (int i = 0; i < 4; i++) sq3_q[i] <= sqr[i][26:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4..18: integer square root, one result bit per stage, two lanes
  // ---------------------------------------------------------------------------
  logic [28:0] sv_q [2][kdr_pkg::SQRT_STEPS+1];
  logic [28:0] sr_q [2][kdr_pkg::SQRT_STEPS+1];
  logic [28:0] sv_d [2][kdr_pkg::SQRT_STEPS];
  logic [28:0] sr_d [2][kdr_pkg::SQRT_STEPS];
  logic [28:0] sbit [kdr_pkg::SQRT_STEPS];
  logic [28:0] strial [2][kdr_pkg::SQRT_STEPS];

  always_comb begin
    for (int j = 0; j < kdr_pkg::SQRT_STEPS; j++) begin
      sbit[j] = 29'd1 << (26 - 2 * j);
      for (int l = 0; l < 2; l++) begin
        strial[l][j] = sr_q[l][j] + sbit[j];
        if (sv_q[l][j] >= strial[l][j]) begin
          sv_d[l][j] = sv_q[l][j] - strial[l][j];
          sr_d[l][j] = (sr_q[l][j] >> 1) + sbit[j];
        end else begin
          sv_d[l][j] = sv_q[l][j];
          sr_d[l][j] = sr_q[l][j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sv_q[0][0] <= {2'b0, sq3_q[0]} + {2'b0, sq3_q[1]};
      sv_q[1][0] <= {2'b0, sq3_q[2]} + {2'b0, sq3_q[3]};
      sr_q[0][0] <= '0;
      sr_q[1][0] <= '0;
      for (int l = 0; l < 2; l++) begin
        for (int j = 0; j < kdr_pkg::SQRT_STEPS; j++) begin
          sv_q[l][j+1] <= sv_d[l][j];
          sr_q[l][j+1] <= sr_d[l][j];
        end
      end
    end
  end

  // Stage 19: round to nearest
  logic [13:0] len19_q, wid19_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len19_q <= 14'(sr_q[0][kdr_pkg::SQRT_STEPS]
                 + {28'b0, sv_q[0][kdr_pkg::SQRT_STEPS] > sr_q[0][kdr_pkg::SQRT_STEPS]});
      wid19_q <= 14'(sr_q[1][kdr_pkg::SQRT_STEPS]
                 + {28'b0, sv_q[1][kdr_pkg::SQRT_STEPS] > sr_q[1][kdr_pkg::SQRT_STEPS]});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 20: ratio numerator and mode, partial softmax sums, sigmoid operands
  // ---------------------------------------------------------------------------
  logic [29:0]   rnum;
  logic [1:0]    rmode;
  logic [29:0]   rnum20_q;
  kdr_pkg::geo_t geo_q [ST_GEO:ST_END-1];
  logic [18:0]   ps20_q [3];
  logic [17:0]   oden;
  logic [33:0]   onum;
  logic [17:0]   oden20_q;
  logic [33:0]   onum20_q;

  always_comb begin
    rnum = {8'b0, len19_q, 8'b0} + {17'b0, wid19_q[13:1]};
    if (wid19_q == 14'd0) rmode = (len19_q != 14'd0) ? RM_SAT : RM_ZERO;
    else if (rnum >= {wid19_q, 16'b0}) rmode = RM_SAT;
    else rmode = RM_DIV;
    oden = 18'h10000 + {1'b0, exp_e[9]};
    if (meta_q[19].neg) onum = {1'b0, exp_e[9], 16'b0} + {17'b0, oden[17:1]};
    else onum = 34'h1_0000_0000 + {17'b0, oden[17:1]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rnum20_q       <= rnum;
      geo_q[ST_GEO]  <= '{len: len19_q, wid: wid19_q, rmode: rmode};
      for (int s = ST_GEO + 1; s < ST_END; s++) geo_q[s] <= geo_q[s-1];
      for (int i = 0; i < 3; i++) begin
        ps20_q[i] <= {2'b0, exp_e[3*i]} + {2'b0, exp_e[3*i+1]} + {2'b0, exp_e[3*i+2]};
      end
      oden20_q <= oden;
      onum20_q <= onum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 21..38: three restoring divider lanes, 17 quotient bits each
  //   lane 0 sigmoid, lane 1 top digit probability, lane 2 aspect ratio
  // ---------------------------------------------------------------------------
  logic [19:0] ssum;
  logic [33:0] rem_q [3][kdr_pkg::DIV_STEPS+1];
  logic [19:0] den_q [3][kdr_pkg::DIV_STEPS+1];
  logic [16:0] quo_q [3][kdr_pkg::DIV_STEPS+1];
  logic [36:0] dsub [3][kdr_pkg::DIV_STEPS];
  logic        dge  [3][kdr_pkg::DIV_STEPS];

  assign ssum = {1'b0, ps20_q[0]} + {1'b0, ps20_q[1]} + {1'b0, ps20_q[2]};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int k = 0; k < kdr_pkg::DIV_STEPS; k++) begin
        dsub[l][k] = {17'b0, den_q[l][k]} << (kdr_pkg::DIV_STEPS - 1 - k);
        dge[l][k]  = {3'b0, rem_q[l][k]} >= dsub[l][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0][0] <= onum20_q;
      den_q[0][0] <= {2'b0, oden20_q};
      rem_q[1][0] <= 34'h1_0000_0000 + {15'b0, ssum[19:1]};
      den_q[1][0] <= ssum;
      rem_q[2][0] <= {4'b0, rnum20_q};
      den_q[2][0] <= {6'b0, geo_q[ST_GEO].wid};
      for (int l = 0; l < 3; l++) begin
        quo_q[l][0] <= '0;
        for (int k = 0; k < kdr_pkg::DIV_STEPS; k++) begin
          den_q[l][k+1] <= den_q[l][k];
          rem_q[l][k+1] <= dge[l][k] ? 34'({3'b0, rem_q[l][k]} - dsub[l][k]) : rem_q[l][k];
          quo_q[l][k+1] <= quo_q[l][k]
                           | ({16'b0, dge[l][k]} << (kdr_pkg::DIV_STEPS - 1 - k));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 39: saturation, confidence product, result assembly
  // ---------------------------------------------------------------------------
  localparam int unsigned QL = kdr_pkg::DIV_STEPS;

  logic [15:0]   objs, probs, ratio;
  logic [31:0]   cprod;
  kdr_pkg::res_t res39;
  kdr_pkg::res_t res39_q;
  logic [15:0]   obj39_q;

  always_comb begin
    objs  = quo_q[0][QL][16] ? kdr_pkg::Q16_MAX : quo_q[0][QL][15:0];
    probs = quo_q[1][QL][16] ? kdr_pkg::Q16_MAX : quo_q[1][QL][15:0];
    case (geo_q[ST_END-1].rmode)
      RM_SAT:  ratio = kdr_pkg::Q16_MAX;
      RM_ZERO: ratio = 16'd0;
      default: ratio = quo_q[2][QL][15:0];
    endcase
    cprod = objs * probs + 32'd32768;
    res39.confidence   = cprod[31:16];
    res39.color_class  = meta_q[ST_END-1].cbest;
    res39.digit_class  = meta_q[ST_END-1].dbest;
    res39.corner_a_out = meta_q[ST_END-1].corners[0];
    res39.corner_b_out = meta_q[ST_END-1].corners[1];
    res39.corner_c_out = meta_q[ST_END-1].corners[2];
    res39.corner_d_out = meta_q[ST_END-1].corners[3];
    res39.box_packed   = meta_q[ST_END-1].box;
    res39.edge_length  = geo_q[ST_END-1].len;
    res39.edge_width   = geo_q[ST_END-1].wid;
    res39.aspect_ratio = ratio;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res39_q <= res39;
      obj39_q <= objs;
    end
  end

  // ---------------------------------------------------------------------------
  // Threshold filter and output register with skid entry
  // ---------------------------------------------------------------------------
  logic keep;
  logic pv;

  assign keep = (obj39_q >= thr_q) && (res39_q.confidence >= thr_q);
  assign pv   = vld_q[ST_END] && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (res_o.ready) skid_vld_q <= 1'b0;
    end else if (pv) begin
      if (!out_vld_q || res_o.ready) out_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (res_o.ready) out_q <= skid_q;
    end else if (pv) begin
      if (!out_vld_q || res_o.ready) out_q <= res39_q;
      else skid_q <= res39_q;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.confidence   = out_q.confidence;
  assign res_o.color_class  = out_q.color_class;
  assign res_o.digit_class  = out_q.digit_class;
  assign res_o.corner_a_out = out_q.corner_a_out;
  assign res_o.corner_b_out = out_q.corner_b_out;
  assign res_o.corner_c_out = out_q.corner_c_out;
  assign res_o.corner_d_out = out_q.corner_d_out;
  assign res_o.box_packed   = out_q.box_packed;
  assign res_o.edge_length  = out_q.edge_length;
  assign res_o.edge_width   = out_q.edge_width;
  assign res_o.aspect_ratio = out_q.aspect_ratio;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry full with empty output register");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !res_o.ready))
    else $error("skid filled without a stalled output word");

  a_box_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ({1'b0, out_q.box_packed[9:0]} + {1'b0, out_q.box_packed[29:20]}
                   <= kdr_pkg::BOX_MAX))
    else $error("box x span leaves the image");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.digit_class <= 4'd8))
    else $error("digit class out of range");

endmodule

@@ rtl/kdr_exp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_exp
// Pipelined e^(-u/256) in Q1.16: 2^-k * e^-z, z via Taylor series up to z^8.
// ----------------------------------------------------------------------------
module kdr_exp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] u_i,
  output logic [16:0] e_o
);

  logic [32:0] w;
  logic [5:0]  ka_q;          // {k >= 32, k[4:0]}
  logic [23:0] fa_q;
  logic [53:0] zprod;
  logic [29:0] z_b;

  logic [29:0] t_q  [1:8];
  logic [29:0] z_q  [1:8];
  logic [5:0]  k_q  [1:8];
  logic [30:0] s_q  [1:8];
  logic [29:0] p_q  [2:8];
  logic [29:0] zm_q [2:8];
  logic [5:0]  km_q [2:8];
  logic [30:0] sm_q [2:8];

  logic [59:0] pm [2:8];
  logic [60:0] dm [2:8];
  logic [29:0] td [2:8];

  logic [5:0]  amt;
  logic [46:0] rnd;
  logic [46:0] shr;
  logic [16:0] e_q;

  assign w     = {16'b0, u_i} * {16'b0, kdr_pkg::LOG2E_Q16};
  assign zprod = {30'b0, fa_q} * {24'b0, kdr_pkg::LN2_Q30};
  assign z_b   = zprod[53:24];

  always_comb begin
    for (int n = 2; n <= 8; n++) begin
      pm[n] = {30'b0, t_q[n-1]} * {30'b0, z_q[n-1]};
      dm[n] = {31'b0, p_q[n]} * {30'b0, kdr_pkg::taylor_recip(n)};
      td[n] = 30'(dm[n] >> kdr_pkg::taylor_shift(n));
    end
  end

  // final rounding shift by 14 + k
  assign amt = 6'd13 + {1'b0, k_q[8][4:0]};
  assign rnd = {16'b0, s_q[8]} + (47'd1 << amt);
  assign shr = rnd >> (amt + 6'd1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ka_q    <= {|w[32:29], w[28:24]};
      fa_q    <= w[23:0];
      t_q[1]  <= z_b;
      z_q[1]  <= z_b;
      k_q[1]  <= ka_q;
      s_q[1]  <= kdr_pkg::ONE_Q30 - {1'b0, z_b};
      for (int n = 2; n <= 8; n++) begin
        p_q[n]  <= pm[n][59:30];
        zm_q[n] <= z_q[n-1];
        km_q[n] <= k_q[n-1];
        sm_q[n] <= s_q[n-1];
        t_q[n]  <= td[n];
        z_q[n]  <= zm_q[n];
        k_q[n]  <= km_q[n];
        s_q[n]  <= (n % 2 == 1) ? sm_q[n] - {1'b0, td[n]} : sm_q[n] + {1'b0, td[n]};
      end
      e_q <= k_q[8][5] ? 17'd0 : shr[16:0];
    end
  end

  assign e_o = e_q;

endmodule

@@ dv/kdr_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_tb_if
// Test-side hookup helpers for the keypoint row decoder channels.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come with the design (kdr_row_if,
// kdr_res_if, kdr_cfg_if). This file only carries the row word type used
// by the bench.
package kdr_tb_pkg;

  typedef struct packed {
    logic [31:0] corner_a_xy;
    logic [31:0] corner_b_xy;
    logic [31:0] corner_c_xy;
    logic [31:0] corner_d_xy;
    logic [15:0] objectness_logit;
    logic [63:0] color_logits;
    logic [63:0] digit_logits_low;
    logic [63:0] digit_logits_high;
    logic [15:0] digit_logit_last;
  } row_word_t;
endpackage

@@ dv/keypoint_detection_row_decode_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_detection_row_decode_core_test
// Self-checking bench for the keypoint row decoder: directed and random rows
// under several thresholds, random stalls on both sides, one long output
// hold-off, and a scoreboard that predicts each decoded word in order.
// ----------------------------------------------------------------------------
module keypoint_detection_row_decode_core_test;

  localparam int PIPE_LAT = 40;
  localparam int STALL_LIMIT = 4000;

  // Golden decoder and in-order store of expected words.
  class decode_scoreboard;
    kdr_pkg::res_t    pending_q[$];
    logic [15:0]      threshold;
    int               errors;

    function new();
      threshold = kdr_pkg::CONF_RESET;
      errors = 0;
    endfunction

    // e^(-u/256) in Q1.16, may reach 65536
    function automatic logic [31:0] exp_q16(logic [31:0] u);
      logic [63:0] w, k, f, z, t, acc;
      w = u * 64'd94548;
      k = w >> 24;
      f = w & 64'hFFFFFF;
      z = (f * 64'd744261118) >> 24;
      t = 64'd1 << 30;
      acc = t;
      if (k >= 32) return 0;
      for (int n = 1; n <= 8; n++) begin
        t = ((t * z) >> 30) / n;
        if (n[0]) acc = acc - t;
        else acc = acc + t;
      end
      return 32'((acc + (64'd1 << (13 + k))) >> (14 + k));
    endfunction

    function automatic logic [15:0] sigmoid_q16(logic signed [15:0] x);
      logic [63:0] e, den, r;
      if (x >= 0) begin
        e = exp_q16(32'(x));
        den = 65536 + e;
        r = (64'h1_0000_0000 + den / 2) / den;
      end else begin
        e = exp_q16(32'(-32'(x)));
        den = 65536 + e;
        r = (e * 65536 + den / 2) / den;
      end
      return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [31:0] root_rounded(logic [31:0] v);
      logic [31:0] r, b;
      r = 0;
      b = 32'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (v > r) r++;
      return r;
    endfunction

    function automatic int clamp_pos(logic signed [15:0] c);
      if (c < 0) return 0;
      if (c > 10240) return 10240;
      return c;
    endfunction

    function automatic logic [31:0] span(int ax, int ay, int bx, int by);
      int dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return root_rounded(32'(dx * dx) + 32'(dy * dy));
    endfunction

    // Row accepted by the block: queue its decoded word, if it survives.
    function void note_row(kdr_tb_pkg::row_word_t r);
      logic signed [15:0] col[4], dig[9];
      logic [15:0] obj, prob, conf;
      logic [31:0] total;
      logic [63:0] p, rr;
      int cb, db, cx[4], cy[4], minx, maxx, miny, maxy;
      logic [31:0] corners[4];
      logic [31:0] len, wid;
      kdr_pkg::res_t w;
      obj = sigmoid_q16(r.objectness_logit);
      if (obj < threshold) return;
      for (int i = 0; i < 4; i++) begin
        col[i] = r.color_logits[16*i +: 16];
        dig[i] = r.digit_logits_low[16*i +: 16];
        dig[i+4] = r.digit_logits_high[16*i +: 16];
      end
      dig[8] = r.digit_logit_last;
      cb = 0;
      db = 0;
      for (int i = 1; i < 4; i++) if (col[i] > col[cb]) cb = i;
      for (int i = 1; i < 9; i++) if (dig[i] > dig[db]) db = i;
      total = 0;
      for (int i = 0; i < 9; i++) total += exp_q16(32'(int'(dig[db]) - int'(dig[i])));
      p = (64'h1_0000_0000 + total / 2) / total;
      prob = (p > 65535) ? 16'hFFFF : p[15:0];
      conf = 16'((64'(obj) * prob + 32768) >> 16);
      if (conf < threshold) return;
      corners = '{r.corner_a_xy, r.corner_b_xy, r.corner_c_xy, r.corner_d_xy};
      for (int i = 0; i < 4; i++) begin
        cx[i] = clamp_pos(corners[i][15:0]);
        cy[i] = clamp_pos(corners[i][31:16]);
      end
      minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
      for (int i = 1; i < 4; i++) begin
        if (cx[i] < minx) minx = cx[i];
        if (cx[i] > maxx) maxx = cx[i];
        if (cy[i] < miny) miny = cy[i];
        if (cy[i] > maxy) maxy = cy[i];
      end
      len = span(cx[0], cy[0], cx[3], cy[3]);
      wid = span(cx[0], cy[0], cx[1], cy[1]);
      w.confidence = conf;
      w.color_class = cb[1:0];
      w.digit_class = db[3:0];
      w.corner_a_out = {16'(cy[0]), 16'(cx[0])};
      w.corner_b_out = {16'(cy[1]), 16'(cx[1])};
      w.corner_c_out = {16'(cy[2]), 16'(cx[2])};
      w.corner_d_out = {16'(cy[3]), 16'(cx[3])};
      w.box_packed = {10'((maxy - miny) >> 4), 10'((maxx - minx) >> 4),
                      10'(miny >> 4), 10'(minx >> 4)};
      w.edge_length = len[13:0];
      w.edge_width = wid[13:0];
      if (wid == 0) begin
        w.aspect_ratio = (len != 0) ? 16'hFFFF : 16'h0;
      end else begin
        rr = (64'(len) * 256 + wid / 2) / wid;
        w.aspect_ratio = (rr > 65535) ? 16'hFFFF : rr[15:0];
      end
      pending_q = {pending_q, w};
    endfunction

    function void check_word(kdr_pkg::res_t got);
      kdr_pkg::res_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.confidence !== exp_w.confidence)
        report("confidence", exp_w.confidence, got.confidence);
      if (got.color_class !== exp_w.color_class)
        report("color_class", exp_w.color_class, got.color_class);
      if (got.digit_class !== exp_w.digit_class)
        report("digit_class", exp_w.digit_class, got.digit_class);
      if (got.corner_a_out !== exp_w.corner_a_out)
        report("corner_a_out", exp_w.corner_a_out, got.corner_a_out);
      if (got.corner_b_out !== exp_w.corner_b_out)
        report("corner_b_out", exp_w.corner_b_out, got.corner_b_out);
      if (got.corner_c_out !== exp_w.corner_c_out)
        report("corner_c_out", exp_w.corner_c_out, got.corner_c_out);
      if (got.corner_d_out !== exp_w.corner_d_out)
        report("corner_d_out", exp_w.corner_d_out, got.corner_d_out);
      if (got.box_packed !== exp_w.box_packed)
        report("box_packed", exp_w.box_packed, got.box_packed);
      if (got.edge_length !== exp_w.edge_length)
        report("edge_length", exp_w.edge_length, got.edge_length);
      if (got.edge_width !== exp_w.edge_width)
        report("edge_width", exp_w.edge_width, got.edge_width);
      if (got.aspect_ratio !== exp_w.aspect_ratio)
        report("aspect_ratio", exp_w.aspect_ratio, got.aspect_ratio);
    endfunction

    function void report(string field, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s expected %h actual %h", $time, field, e, a);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kdr_cfg_if cfg_if ();
  kdr_row_if row_if ();
  kdr_res_if res_if ();

  keypoint_detection_row_decode_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .row_i  (row_if.sink),
    .res_o  (res_if.source)
  );

  decode_scoreboard sb;
  int  idle_cycles;     // cycles with no handshake on any channel
  bit  calm;            // no random stalls in the last part
  bit  hold_off;        // long receiver stall in progress

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Everything driven from a known value at time zero.
  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.conf_threshold = '0;
    row_if.valid = 1'b0;
    row_if.corner_a_xy = '0;
    row_if.corner_b_xy = '0;
    row_if.corner_c_xy = '0;
    row_if.corner_d_xy = '0;
    row_if.objectness_logit = '0;
    row_if.color_logits = '0;
    row_if.digit_logits_low = '0;
    row_if.digit_logits_high = '0;
    row_if.digit_logit_last = '0;
    res_if.ready = 1'b0;
    calm = 1'b0;
    hold_off = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result side: checks on accept, stalls in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_word('{res_if.confidence, res_if.color_class, res_if.digit_class,
                      res_if.corner_a_out, res_if.corner_b_out, res_if.corner_c_out,
                      res_if.corner_d_out, res_if.box_packed, res_if.edge_length,
                      res_if.edge_width, res_if.aspect_ratio});
    end
  end

  initial begin : res_stall
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        res_if.ready <= 1'b0;
        // long hold-off, counted here, lets the pipeline back up into the input
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        n = calm ? 1 : $urandom_range(1, 30);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (row_if.valid && row_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_row(kdr_tb_pkg::row_word_t r);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      row_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    row_if.valid <= 1'b1;
    row_if.corner_a_xy <= r.corner_a_xy;
    row_if.corner_b_xy <= r.corner_b_xy;
    row_if.corner_c_xy <= r.corner_c_xy;
    row_if.corner_d_xy <= r.corner_d_xy;
    row_if.objectness_logit <= r.objectness_logit;
    row_if.color_logits <= r.color_logits;
    row_if.digit_logits_low <= r.digit_logits_low;
    row_if.digit_logits_high <= r.digit_logits_high;
    row_if.digit_logit_last <= r.digit_logit_last;
    do @(posedge clk_i); while (!row_if.ready);
    sb.note_row(r);
  endtask

  task automatic drain();
    row_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    // dropped rows may still be in flight
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [15:0] th);
    cfg_if.valid <= 1'b1;
    cfg_if.conf_threshold <= th;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.threshold = th;
  endtask

  // Corner coordinate: mostly on-image, sometimes anywhere, near the far edge or just below zero.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(10200, 10300));
      2: return 16'(-$urandom_range(0, 60));
      default: return 16'($urandom_range(0, 10240));
    endcase
  endfunction

  function automatic logic [15:0] rand_logit();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      default: return 16'($urandom_range(0, 2048) - 1024);
    endcase
  endfunction

  function automatic kdr_tb_pkg::row_word_t rand_row();
    kdr_tb_pkg::row_word_t r;
    r.corner_a_xy = {rand_coord(), rand_coord()};
    r.corner_b_xy = {rand_coord(), rand_coord()};
    r.corner_c_xy = {rand_coord(), rand_coord()};
    r.corner_d_xy = {rand_coord(), rand_coord()};
    // zero width: corner b on top of corner a
    if ($urandom_range(0, 15) == 0) r.corner_b_xy = r.corner_a_xy;
    // mostly rows that pass objectness, to reach the later stages
    r.objectness_logit = ($urandom_range(0, 3) == 0) ? rand_logit()
                                                      : 16'($urandom_range(0, 3000));
    for (int i = 0; i < 4; i++) begin
      r.color_logits[16*i +: 16] = rand_logit();
      r.digit_logits_low[16*i +: 16] = rand_logit();
      r.digit_logits_high[16*i +: 16] = rand_logit();
    end
    r.digit_logit_last = rand_logit();
    // one dominant digit so the confidence survives often
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 1) == 0) r.digit_logit_last = 16'sd6000;
      else r.digit_logits_low[16*$urandom_range(0, 3) +: 16] = 16'sd6000;
    end
    // equal logits exercise first-index tie break
    if ($urandom_range(0, 7) == 0) r.color_logits = {4{r.color_logits[15:0]}};
    if ($urandom_range(0, 7) == 0) begin
      r.digit_logits_low = {4{r.digit_logit_last}};
      r.digit_logits_high = {4{r.digit_logit_last}};
    end
    return r;
  endfunction

  initial begin : stimulus
    kdr_tb_pkg::row_word_t r;
    logic [15:0] ths[6];
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed rows at reset threshold.
    r = '0;
    r.objectness_logit = 16'sh7FFF;
    r.digit_logit_last = 16'sh7FFF;
    send_row(r);                                 // all-zero corners, zero width
    r.corner_a_xy = 32'hFFFF_FFFF;
    r.corner_b_xy = 32'h7FFF_7FFF;
    r.corner_c_xy = 32'h8000_8000;
    r.corner_d_xy = {16'd10240, 16'd10240};
    r.color_logits = 64'h7FFF_8000_7FFF_0000;
    r.digit_logits_low = 64'h8000_8000_8000_8000;
    r.digit_logits_high = 64'h7FFF_0000_0000_0000;
    send_row(r);                                 // clamping both ends, ties
    r.corner_b_xy = r.corner_a_xy;               // zero width with nonzero length
    send_row(r);
    r = '0;
    r.objectness_logit = 16'sh8000;              // lowest logit, dropped
    send_row(r);
    r.objectness_logit = 16'sd0;                 // sigmoid exactly 0.5 passes at reset
    r.corner_b_xy = {16'd0, 16'd16};
    r.corner_d_xy = {16'd10240, 16'd0};          // ratio saturates
    send_row(r);
    r.digit_logits_low = '1;
    r.digit_logits_high = '1;
    r.color_logits = '1;
    r.digit_logit_last = 16'hFFFF;               // all -1/256, equal
    send_row(r);
    for (int i = 0; i < 8; i++) send_row(rand_row());
    drain();

    // Phases over thresholds, the extremes among them.
    ths = '{16'd0, 16'hFFFF, 16'd32768, 16'd50000, 16'd1, 16'd20000};
    foreach (ths[p]) begin
      set_threshold(ths[p]);
      for (int i = 0; i < 190; i++) begin
        if (p == 2 && i == 20) hold_off = 1'b1;
        if (p == 5 && i == 150) calm = 1'b1;
        r = rand_row();
        send_row(r);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ keypoint_detection_row_decode_core.f @@
rtl/kdr_pkg.sv
rtl/kdr_if.sv
rtl/kdr_exp.sv
rtl/keypoint_detection_row_decode_core.sv
dv/kdr_tb_if.sv
dv/keypoint_detection_row_decode_core_test.sv
